// ===== rtl/core/idss_pkg.sv =====
package idss_pkg;

	localparam int DIM_BITS     = 13;
	localparam int MAX_SCALE    = 64;
	localparam int SCALE_W      = 11;
	localparam int PROD_W       = DIM_BITS + SCALE_W;
	localparam int CFG_IDX_W    = 3;
	localparam int OFFSET_SLACK = 4;

	typedef logic [DIM_BITS-1:0]  dim_t;
	typedef logic [SCALE_W-1:0]   scale_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_MIN_W = 3'd0;
	localparam cfg_idx_t REG_MAX_W = 3'd1;
	localparam cfg_idx_t REG_MIN_H = 3'd2;
	localparam cfg_idx_t REG_MAX_H = 3'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LIMW,
		ST_LIMH,
		ST_TOP,
		ST_DIVW,
		ST_DIVH,
		ST_MULW,
		ST_MULH,
		ST_EVAL,
		ST_SCW,
		ST_SCH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		dim_t dividend;
		dim_t divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		dim_t quotient;
	} div_rsp_t;

endpackage

// ===== rtl/core/idss_if.sv =====
interface idss_in_if import idss_pkg::*; ();
	logic valid;
	logic ready;
	dim_t panel_width;
	dim_t panel_height;

	modport source (output valid, output panel_width, output panel_height, input ready);
	modport sink (input valid, input panel_width, input panel_height, output ready);
endinterface

interface idss_out_if import idss_pkg::*; ();
	logic   valid;
	logic   ready;
	dim_t   content_width;
	dim_t   content_height;
	scale_t scale;
	dim_t   x_offset;
	dim_t   y_offset;
	dim_t   scaled_width;
	dim_t   scaled_height;
	logic   no_fit;

	modport source (output valid, output content_width, output content_height, output scale,
		output x_offset, output y_offset, output scaled_width, output scaled_height,
		output no_fit, input ready);
	modport sink (input valid, input content_width, input content_height, input scale,
		input x_offset, input y_offset, input scaled_width, input scaled_height,
		input no_fit, output ready);
endinterface

interface idss_cfg_if import idss_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	dim_t     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/idss_div.sv =====
module idss_div import idss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIM_BITS + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	dim_t             rem_q;
	dim_t             quo_q;
	dim_t             dvs_q;

	logic [DIM_BITS:0] trial_w;
	logic              ge_w;
	logic [DIM_BITS:0] diff_w;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign trial_w = {rem_q, quo_q[DIM_BITS-1]};
	assign ge_w    = trial_w >= {1'b0, dvs_q};
	assign diff_w  = trial_w - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge_w ? diff_w[DIM_BITS-1:0] : trial_w[DIM_BITS-1:0];
			quo_q <= {quo_q[DIM_BITS-2:0], ge_w};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/core/integer_display_scale_selector_top.sv =====
// channel | dir | beat                                   | handshake
// req     | in  | panel_width, panel_height              | valid/ready
// rsp     | out | content size, scale, offsets, scaled   | valid/ready
//         |     | size, no_fit                           |
// cfg     | in  | index, data (register write)           | valid/ready, ready always high
// One beat at a time, with at most 64 trial scales per beat.
// Each trial runs two 13-step divisions on the single serial divider plus two multiplies
// and a compare; the two axis limits take one division each unless that axis minimum is zero.
// Reset clears the registers to their defaults and the kept pick to scale 1, the rest of it zero.
// A finished beat waits in the output register; req is taken again as soon as the
// sequencer is back in idle, and a stalled rsp holds the last step until the register frees.
module integer_display_scale_selector_top import idss_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	idss_in_if.sink    req,
	idss_out_if.source rsp,
	idss_cfg_if.sink   cfg
);

	localparam scale_t MAX_S = SCALE_W'(MAX_SCALE);

	function automatic dim_t clamp_dim(dim_t v, dim_t lo, dim_t hi);
		dim_t r;
		r = v;
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

	function automatic scale_t sat_scale(dim_t q);
		return (q > DIM_BITS'(MAX_SCALE)) ? MAX_S : q[SCALE_W-1:0];
	endfunction

	state_t state_q, state_d;
	logic   pend_q;
	logic   out_valid_q;

	dim_t   min_w_q, max_w_q, min_h_q, max_h_q;
	dim_t   kept_cw_q, kept_ch_q, kept_x_q, kept_y_q;
	scale_t kept_scale_q;

	dim_t              pw_q, ph_q;
	scale_t            lw_q, lh_q, top_q, s_q;
	dim_t              cw_q, ch_q;
	logic [PROD_W-1:0] usedw_q, usedh_q;
	dim_t              scw_q, sch_q;
	logic              fit_q;

	dim_t   o_cw_q, o_ch_q, o_x_q, o_y_q, o_scw_q, o_sch_q;
	scale_t o_scale_q;
	logic   o_nofit_q;

	div_req_t          div_req;
	div_rsp_t          div_rsp;
	dim_t              mul_a;
	scale_t            mul_b;
	logic [PROD_W-1:0] mul_w;
	logic              ld_out;
	logic              take_in;

	scale_t            top_w;
	logic [PROD_W-1:0] pw_ext, ph_ext, gapw_w, gaph_w;
	logic [DIM_BITS:0] gw1_w, gh1_w;
	dim_t              xo_w, yo_w;
	logic [DIM_BITS:0] cur_sum_w, new_sum_w;
	logic              take_w;
	logic              last_w;

	idss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign mul_w = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign top_w = (lw_q < lh_q) ? lw_q : lh_q;

	// half the letterbox gap, rounded up; the gap saturates at zero when content overhangs the panel
	assign pw_ext = PROD_W'(pw_q);
	assign ph_ext = PROD_W'(ph_q);
	assign gapw_w = (pw_ext >= usedw_q) ? pw_ext - usedw_q : '0;
	assign gaph_w = (ph_ext >= usedh_q) ? ph_ext - usedh_q : '0;
	assign gw1_w  = {1'b0, gapw_w[DIM_BITS-1:0]} + (DIM_BITS+1)'(1);
	assign gh1_w  = {1'b0, gaph_w[DIM_BITS-1:0]} + (DIM_BITS+1)'(1);
	assign xo_w   = gw1_w[DIM_BITS:1];
	assign yo_w   = gh1_w[DIM_BITS:1];

	assign cur_sum_w = {1'b0, kept_x_q} + {1'b0, kept_y_q};
	assign new_sum_w = {1'b0, xo_w} + {1'b0, yo_w};
	assign take_w    = (s_q == SCALE_W'(1))
		|| ((cur_sum_w > (DIM_BITS+1)'(OFFSET_SLACK)) && (new_sum_w < cur_sum_w));
	assign last_w    = (s_q == top_q);

	assign req.ready = (state_q == ST_IDLE);
	assign take_in   = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = pw_q;
		div_req.divisor  = min_w_q;
		mul_a            = cw_q;
		mul_b            = s_q;
		ld_out           = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_LIMW;
			end
			ST_LIMW: begin
				if (min_w_q == '0) begin
					state_d = ST_LIMH;
				end else begin
					div_req.start = !pend_q;
					if (div_rsp.done) state_d = ST_LIMH;
				end
			end
			ST_LIMH: begin
				div_req.dividend = ph_q;
				div_req.divisor  = min_h_q;
				if (min_h_q == '0) begin
					state_d = ST_TOP;
				end else begin
					div_req.start = !pend_q;
					if (div_rsp.done) state_d = ST_TOP;
				end
			end
			ST_TOP: begin
				state_d = (top_w == '0) ? ST_SCW : ST_DIVW;
			end
			ST_DIVW: begin
				div_req.divisor = DIM_BITS'(s_q);
				div_req.start   = !pend_q;
				if (div_rsp.done) state_d = ST_DIVH;
			end
			ST_DIVH: begin
				div_req.dividend = ph_q;
				div_req.divisor  = DIM_BITS'(s_q);
				div_req.start    = !pend_q;
				if (div_rsp.done) state_d = ST_MULW;
			end
			ST_MULW: begin
				state_d = ST_MULH;
			end
			ST_MULH: begin
				mul_a   = ch_q;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = last_w ? ST_SCW : ST_DIVW;
			end
			ST_SCW: begin
				mul_a   = kept_cw_q;
				mul_b   = kept_scale_q;
				state_d = ST_SCH;
			end
			ST_SCH: begin
				mul_a   = kept_ch_q;
				mul_b   = kept_scale_q;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			min_w_q      <= DIM_BITS'(1);
			max_w_q      <= DIM_BITS'(8191);
			min_h_q      <= DIM_BITS'(1);
			max_h_q      <= DIM_BITS'(8191);
			kept_cw_q    <= '0;
			kept_ch_q    <= '0;
			kept_scale_q <= SCALE_W'(1);
			kept_x_q     <= '0;
			kept_y_q     <= '0;
		end else begin
			state_q <= state_d;
			if (div_req.start) pend_q <= 1'b1;
			else if (div_rsp.done) pend_q <= 1'b0;

			if (ld_out) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;

			if (cfg.valid) begin
				if (cfg.index == REG_MIN_W) min_w_q <= cfg.data;
				if (cfg.index == REG_MAX_W) max_w_q <= cfg.data;
				if (cfg.index == REG_MIN_H) min_h_q <= cfg.data;
				if (cfg.index == REG_MAX_H) max_h_q <= cfg.data;
			end

			if (state_q == ST_EVAL && take_w) begin
				kept_cw_q    <= cw_q;
				kept_ch_q    <= ch_q;
				kept_scale_q <= s_q;
				kept_x_q     <= xo_w;
				kept_y_q     <= yo_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			pw_q <= req.panel_width;
			ph_q <= req.panel_height;
		end
		case (state_q)
			ST_LIMW: begin
				if (min_w_q == '0) lw_q <= MAX_S;
				else if (div_rsp.done) lw_q <= sat_scale(div_rsp.quotient);
			end
			ST_LIMH: begin
				if (min_h_q == '0) lh_q <= MAX_S;
				else if (div_rsp.done) lh_q <= sat_scale(div_rsp.quotient);
			end
			ST_TOP: begin
				top_q <= top_w;
				s_q   <= SCALE_W'(1);
				fit_q <= (top_w != '0);
			end
			ST_DIVW: begin
				if (div_rsp.done) cw_q <= clamp_dim(div_rsp.quotient, min_w_q, max_w_q);
			end
			ST_DIVH: begin
				if (div_rsp.done) ch_q <= clamp_dim(div_rsp.quotient, min_h_q, max_h_q);
			end
			ST_MULW: usedw_q <= mul_w;
			ST_MULH: usedh_q <= mul_w;
			ST_EVAL: begin
				if (!last_w) s_q <= s_q + SCALE_W'(1);
			end
			ST_SCW:  scw_q <= mul_w[DIM_BITS-1:0];
			ST_SCH:  sch_q <= mul_w[DIM_BITS-1:0];
			default: ;
		endcase
		if (ld_out) begin
			o_cw_q    <= kept_cw_q;
			o_ch_q    <= kept_ch_q;
			o_scale_q <= kept_scale_q;
			o_x_q     <= kept_x_q;
			o_y_q     <= kept_y_q;
			o_scw_q   <= scw_q;
			o_sch_q   <= sch_q;
			o_nofit_q <= !fit_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.content_width  = o_cw_q;
	assign rsp.content_height = o_ch_q;
	assign rsp.scale          = o_scale_q;
	assign rsp.x_offset       = o_x_q;
	assign rsp.y_offset       = o_y_q;
	assign rsp.scaled_width   = o_scw_q;
	assign rsp.scaled_height  = o_sch_q;
	assign rsp.no_fit         = o_nofit_q;

endmodule

// ===== rtl/core/idss_checker.sv =====
module idss_checker import idss_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   req_valid,
	input logic   req_ready,
	input logic   rsp_valid,
	input logic   rsp_ready,
	input dim_t   content_width,
	input dim_t   scaled_width,
	input scale_t scale,
	input logic   no_fit
);

	// the sequencer leaves idle on every accepted beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req ready right after an accepted beat");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(scale) && $stable(no_fit)
		&& $stable(content_width) && $stable(scaled_width))
		else $error("stalled rsp beat changed");

	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (scale != '0) && (scale <= SCALE_W'(MAX_SCALE)))
		else $error("rsp scale out of range");

	a_scaled_width: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> scaled_width == DIM_BITS'(content_width * scale))
		else $error("scaled width does not match content width times scale");

endmodule

bind integer_display_scale_selector_top idss_checker u_idss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.content_width (rsp.content_width),
	.scaled_width  (rsp.scaled_width),
	.scale         (rsp.scale),
	.no_fit        (rsp.no_fit)
);

// ===== bench/tb_top.sv =====
module tb_top;
	import idss_pkg::*;

	localparam int       WATCHDOG_LIMIT = 40000;
	localparam int       HOLD_CYCLES    = 4000;
	localparam int       IDLE_PCT       = 13;
	localparam int       MAX_SHOWN      = 10;
	localparam int       DIM_MAX        = (1 << DIM_BITS) - 1;
	localparam cfg_idx_t REG_UNUSED     = REG_MAX_H + cfg_idx_t'(1);

	typedef struct packed {
		dim_t   content_width;
		dim_t   content_height;
		scale_t scale;
		dim_t   x_offset;
		dim_t   y_offset;
		dim_t   scaled_width;
		dim_t   scaled_height;
		logic   no_fit;
	} pick_t;

	logic clk = 1'b0;
	logic arst_n;

	idss_in_if  req_ch ();
	idss_out_if rsp_ch ();
	idss_cfg_if cfg_ch ();

	integer_display_scale_selector_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bench copy of the registers and the kept pick
	dim_t   min_w = dim_t'(1);
	dim_t   max_w = dim_t'(DIM_MAX);
	dim_t   min_h = dim_t'(1);
	dim_t   max_h = dim_t'(DIM_MAX);
	dim_t   kept_cw = '0;
	dim_t   kept_ch = '0;
	scale_t kept_scale = scale_t'(1);
	dim_t   kept_xo = '0;
	dim_t   kept_yo = '0;

	pick_t expected_picks[$];
	int    mismatches = 0;
	logic  calm = 1'b0;
	int    hold_token = 0;
	int    hold_seen = 0;
	int    hold_left = 0;
	int    stall_cycles = 0;

	function automatic int unsigned axis_cap(input int unsigned panel, input int unsigned lo);
		if (lo == 0)
			return MAX_SCALE;
		return (panel / lo > MAX_SCALE) ? MAX_SCALE : panel / lo;
	endfunction

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lo,
		input int unsigned hi);
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		return v;
	endfunction

	function automatic int unsigned half_gap(input int unsigned panel, input int unsigned used);
		int unsigned d;
		d = (panel >= used) ? panel - used : 0;
		return (d + 1) >> 1;
	endfunction

	// advance the kept pick for one panel and return the beat it produces
	function automatic pick_t pick_scale(input dim_t pw, input dim_t ph);
		int unsigned top, cw, ch, xo, yo, cur;
		pick_t p;
		top = axis_cap(pw, min_w);
		if (axis_cap(ph, min_h) < top)
			top = axis_cap(ph, min_h);
		for (int unsigned s = 1; s <= top; s++) begin
			cw  = clamp_dim(pw / s, min_w, max_w);
			ch  = clamp_dim(ph / s, min_h, max_h);
			xo  = half_gap(pw, cw * s);
			yo  = half_gap(ph, ch * s);
			cur = int'(kept_xo) + int'(kept_yo);
			if (s == 1 || (cur > OFFSET_SLACK && xo + yo < cur)) begin
				kept_xo    = dim_t'(xo);
				kept_yo    = dim_t'(yo);
				kept_cw    = dim_t'(cw);
				kept_ch    = dim_t'(ch);
				kept_scale = scale_t'(s);
			end
		end
		p.content_width  = kept_cw;
		p.content_height = kept_ch;
		p.scale          = kept_scale;
		p.x_offset       = kept_xo;
		p.y_offset       = kept_yo;
		p.scaled_width   = dim_t'(32'(kept_cw) * 32'(kept_scale));
		p.scaled_height  = dim_t'(32'(kept_ch) * 32'(kept_scale));
		p.no_fit         = (top < 1);
		return p;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("mismatch %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// receiver: random ready, long hold-off on request, check each result beat
	always @(posedge clk) begin
		pick_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_picks.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("result beat with nothing pending");
			end else begin
				want = expected_picks.pop_front();
				check_field("content_width", want.content_width, rsp_ch.content_width);
				check_field("content_height", want.content_height, rsp_ch.content_height);
				check_field("scale", want.scale, rsp_ch.scale);
				check_field("x_offset", want.x_offset, rsp_ch.x_offset);
				check_field("y_offset", want.y_offset, rsp_ch.y_offset);
				check_field("scaled_width", want.scaled_width, rsp_ch.scaled_width);
				check_field("scaled_height", want.scaled_height, rsp_ch.scaled_height);
				check_field("no_fit", want.no_fit, rsp_ch.no_fit);
			end
		end
		if (hold_token != hold_seen) begin
			hold_seen    <= hold_token;
			hold_left    <= HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// offer one panel beat; valid stays high after acceptance until the next call or flush
	task automatic send_panel(input dim_t pw, input dim_t ph);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.panel_width  <= pw;
		req_ch.panel_height <= ph;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		expected_picks.push_back(pick_scale(pw, ph));
	endtask

	task automatic flush();
		req_ch.valid <= 1'b0;
		while (expected_picks.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input dim_t val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			REG_MIN_W: min_w = val;
			REG_MAX_W: max_w = val;
			REG_MIN_H: min_h = val;
			REG_MAX_H: max_h = val;
			default: ;
		endcase
	endtask

	task automatic program_regs(input dim_t lo_w, input dim_t hi_w, input dim_t lo_h,
		input dim_t hi_h);
		flush();
		write_reg(REG_MIN_W, lo_w);
		write_reg(REG_MAX_W, hi_w);
		write_reg(REG_MIN_H, lo_h);
		write_reg(REG_MAX_H, hi_h);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic test_defaults_directed();
		send_panel(dim_t'(0), dim_t'(0));
		send_panel(dim_t'(DIM_MAX), dim_t'(DIM_MAX));
		send_panel(dim_t'(1), dim_t'(1));
		send_panel(dim_t'(DIM_MAX), dim_t'(0));
		send_panel(dim_t'(0), dim_t'(DIM_MAX));
		send_panel(dim_t'(13'h1555), dim_t'(13'h0aaa));
		send_panel(dim_t'(1234), dim_t'(567));
	endtask

	task automatic test_zero_minimum();
		program_regs(dim_t'(0), dim_t'(300), dim_t'(0), dim_t'(DIM_MAX));
		send_panel(dim_t'(0), dim_t'(0));
		send_panel(dim_t'(1921), dim_t'(1079));
		send_panel(dim_t'(5), dim_t'(DIM_MAX));
	endtask

	task automatic test_inverted_clamp();
		program_regs(dim_t'(500), dim_t'(100), dim_t'(400), dim_t'(90));
		send_panel(dim_t'(1920), dim_t'(1080));
		send_panel(dim_t'(DIM_MAX), dim_t'(DIM_MAX));
		send_panel(dim_t'(100), dim_t'(1080));
	endtask

	task automatic test_register_extremes();
		program_regs(dim_t'(DIM_MAX), dim_t'(DIM_MAX), dim_t'(DIM_MAX), dim_t'(DIM_MAX));
		send_panel(dim_t'(DIM_MAX), dim_t'(DIM_MAX));
		send_panel(dim_t'(DIM_MAX - 1), dim_t'(DIM_MAX));
		program_regs(dim_t'(1), dim_t'(1), dim_t'(1), dim_t'(1));
		send_panel(dim_t'(640), dim_t'(480));
		send_panel(dim_t'(DIM_MAX), dim_t'(3));
	endtask

	task automatic test_ignored_index();
		program_regs(dim_t'(160), dim_t'(800), dim_t'(120), dim_t'(600));
		for (int i = 0; i < 4; i++)
			write_reg(REG_UNUSED | cfg_idx_t'(i), dim_t'($urandom_range(DIM_MAX)));
		cfg_ch.valid <= 1'b0;
		send_panel(dim_t'(1920), dim_t'(1080));
		send_panel(dim_t'(100), dim_t'(1080));
	endtask

	// hold the result side off while panels keep coming, so the input stalls
	task automatic test_output_stall();
		program_regs(dim_t'(900), dim_t'(DIM_MAX), dim_t'(700), dim_t'(DIM_MAX));
		hold_token <= hold_token + 1;
		for (int i = 0; i < 12; i++)
			send_panel(dim_t'($urandom_range(DIM_MAX)), dim_t'($urandom_range(DIM_MAX)));
		flush();
	endtask

	function automatic dim_t random_min();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return dim_t'(0);
		if (pick < 25)
			return dim_t'($urandom_range(16, 1));
		if (pick < 90)
			return dim_t'($urandom_range(3000, 100));
		return dim_t'($urandom_range(DIM_MAX, 1));
	endfunction

	function automatic dim_t random_max(input dim_t lo);
		if ($urandom_range(99) < 15)
			return dim_t'($urandom_range(DIM_MAX));
		if ($urandom_range(99) < 30)
			return dim_t'(DIM_MAX);
		return dim_t'($urandom_range(DIM_MAX, lo));
	endfunction

	function automatic dim_t random_panel(input dim_t lo);
		if ($urandom_range(99) < 15)
			return dim_t'($urandom_range(lo));
		return dim_t'($urandom_range(DIM_MAX));
	endfunction

	task automatic test_random_panels();
		dim_t lo_w, lo_h;
		for (int phase = 0; phase < 11; phase++) begin
			lo_w = random_min();
			lo_h = random_min();
			program_regs(lo_w, random_max(lo_w), lo_h, random_max(lo_h));
			calm <= (phase == 5);
			for (int i = 0; i < 50; i++)
				send_panel(random_panel(min_w), random_panel(min_h));
		end
		flush();
		calm <= 1'b0;
	endtask

	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.panel_width  = '0;
		req_ch.panel_height = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults_directed();
		test_zero_minimum();
		test_inverted_clamp();
		test_register_extremes();
		test_ignored_index();
		test_output_stall();
		test_random_panels();
		flush();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
